FILE: hdl/sbrpm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, widths and control types of the stereo RMS and peak meter.
package sbrpm_pkg;

  localparam int unsigned WORD_W         = 32;  // raw input word
  localparam int unsigned SAMP_W         = 24;  // signed sample, word[31:8]
  localparam int unsigned SAMP_SHIFT     = 8;
  localparam int unsigned SQR_W          = 2 * SAMP_W - 1;  // square of a sample
  localparam int unsigned CNT_W          = 9;   // frame count, up to 256
  localparam int unsigned SUM_W          = 32;
  localparam int unsigned SQ_W           = 56;
  localparam int unsigned SQ_SPLIT       = 28;  // n * sumsq is done in two halves
  localparam int unsigned PROD_W         = 64;
  localparam int unsigned NN_W           = 2 * CNT_W;  // n * n
  localparam int unsigned ROOT_W         = PROD_W / 2;
  localparam int unsigned MAX_FRAMES_DEF = 256;

  localparam int unsigned IN_TDATA_W  = 2 * WORD_W;
  localparam int unsigned OUT_FIELD_W = 4 * SAMP_W + CNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic ch;          // channel under computation
    logic pre0;        // mag^2, n * sumsq low half, n * n
    logic pre1;        // n * sumsq high half
    logic pre2;        // join the halves
    logic pre3;        // subtract and clamp
    logic div_start;
    logic sqrt_start;
    logic take_rms;
    logic load_out;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } status_t;

endpackage

FILE: hdl/sbrpm_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module sbrpm_div #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned StepW = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [StepW-1:0] step_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   trial, trial_sub;
  logic             ge;

  assign trial     = {rem_q, quo_q[NUM_W-1]};
  assign ge        = trial >= {1'b0, den_i};
  assign trial_sub = trial - {1'b0, den_i};
  assign rem_d     = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(NUM_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: hdl/sbrpm_sqrt.sv
`timescale 1ns / 1ps
// Integer square root, one root bit per cycle (two radicand bits per step).
module sbrpm_sqrt #(
  parameter int unsigned IN_W = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [IN_W-1:0]   rad_i,
  output logic              done_o,
  output logic [IN_W/2-1:0] root_o
);

  localparam int unsigned RootW = IN_W / 2;
  localparam int unsigned RemW  = RootW + 2;
  localparam int unsigned StepW = $clog2(RootW);

  logic             busy_q, done_q;
  logic [StepW-1:0] step_q;
  logic [IN_W-1:0]  x_q;
  logic [RootW-1:0] root_q;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RemW+1:0]  shifted, trial, shifted_sub;
  logic             ge;

  assign shifted     = {rem_q, x_q[IN_W-1 -: 2]};
  assign trial       = {2'b00, root_q, 2'b01};
  assign ge          = shifted >= trial;
  assign shifted_sub = shifted - trial;
  assign rem_d       = ge ? shifted_sub[RemW-1:0] : shifted[RemW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(RootW - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[IN_W-3:0], 2'b00};
      root_q <= {root_q[RootW-2:0], ge};
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: hdl/sbrpm_datapath.sv
`timescale 1ns / 1ps
// Datapath: frame accumulators, RMS arithmetic and result register.
module sbrpm_datapath #(
  parameter int unsigned MAX_FRAMES = sbrpm_pkg::MAX_FRAMES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sbrpm_pkg::cmd_t                cmd_i,
  output sbrpm_pkg::status_t             status_o,
  input  logic [sbrpm_pkg::WORD_W-1:0]   left_word_i,
  input  logic [sbrpm_pkg::WORD_W-1:0]   right_word_i,
  output logic [sbrpm_pkg::SAMP_W-1:0]   left_rms_o,
  output logic [sbrpm_pkg::SAMP_W-1:0]   left_peak_o,
  output logic [sbrpm_pkg::SAMP_W-1:0]   right_rms_o,
  output logic [sbrpm_pkg::SAMP_W-1:0]   right_peak_o,
  output logic [sbrpm_pkg::CNT_W-1:0]    frame_total_o,
  output logic                           overrun_o
);

  import sbrpm_pkg::*;

  // accept stage: frame count and drop flag
  logic [CNT_W-1:0] cnt_q;
  logic             drop_q;
  logic             keep;

  assign keep = cnt_q < CNT_W'(MAX_FRAMES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else if (cmd_i.clear) begin
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else if (cmd_i.accept) begin
      if (keep) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        drop_q <= 1'b1;
      end
    end
  end

  // stage 1: sample, square and magnitude
  logic signed [SAMP_W-1:0]   samp_l, samp_r;
  logic signed [2*SAMP_W-1:0] sq_full_l, sq_full_r;
  logic [SAMP_W-1:0]          abs_l, abs_r;

  assign samp_l    = left_word_i[WORD_W-1:SAMP_SHIFT];
  assign samp_r    = right_word_i[WORD_W-1:SAMP_SHIFT];
  assign sq_full_l = samp_l * samp_l;
  assign sq_full_r = samp_r * samp_r;
  assign abs_l     = samp_l[SAMP_W-1] ? (~samp_l + 1'b1) : samp_l;
  assign abs_r     = samp_r[SAMP_W-1] ? (~samp_r + 1'b1) : samp_r;

  logic              s1_valid_q, s1_keep_q;
  logic [SAMP_W-1:0] s1_samp_l_q, s1_samp_r_q, s1_abs_l_q, s1_abs_r_q;
  logic [SQR_W-1:0]  s1_sq_l_q, s1_sq_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_keep_q  <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.accept;
      s1_keep_q  <= keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s1_samp_l_q <= samp_l;
      s1_samp_r_q <= samp_r;
      s1_sq_l_q   <= sq_full_l[SQR_W-1:0];
      s1_sq_r_q   <= sq_full_r[SQR_W-1:0];
      s1_abs_l_q  <= abs_l;
      s1_abs_r_q  <= abs_r;
    end
  end

  // stage 2: accumulate
  logic [SUM_W-1:0]  sum_l_q, sum_r_q;
  logic [SQ_W-1:0]   sq_l_q, sq_r_q;
  logic [SAMP_W-1:0] peak_l_q, peak_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_l_q  <= '0;
      sum_r_q  <= '0;
      sq_l_q   <= '0;
      sq_r_q   <= '0;
      peak_l_q <= '0;
      peak_r_q <= '0;
    end else if (cmd_i.clear) begin
      sum_l_q  <= '0;
      sum_r_q  <= '0;
      sq_l_q   <= '0;
      sq_r_q   <= '0;
      peak_l_q <= '0;
      peak_r_q <= '0;
    end else if (s1_valid_q && s1_keep_q) begin
      sum_l_q <= sum_l_q + {{(SUM_W-SAMP_W){s1_samp_l_q[SAMP_W-1]}}, s1_samp_l_q};
      sum_r_q <= sum_r_q + {{(SUM_W-SAMP_W){s1_samp_r_q[SAMP_W-1]}}, s1_samp_r_q};
      sq_l_q  <= sq_l_q + {{(SQ_W-SQR_W){1'b0}}, s1_sq_l_q};
      sq_r_q  <= sq_r_q + {{(SQ_W-SQR_W){1'b0}}, s1_sq_r_q};
      if (s1_abs_l_q > peak_l_q) begin
        peak_l_q <= s1_abs_l_q;
      end
      if (s1_abs_r_q > peak_r_q) begin
        peak_r_q <= s1_abs_r_q;
      end
    end
  end

  // RMS numerator: n * sumsq - sum^2, clamped at zero
  logic [SUM_W-1:0]            sel_sum, mag;
  logic [SQ_W-1:0]             sel_sq;
  logic [PROD_W-1:0]           den_full;
  logic [CNT_W+SQ_SPLIT-1:0]   plo_full;
  logic [CNT_W+SQ_W-SQ_SPLIT-1:0] phi_full;
  logic [NN_W-1:0]             nn_full;

  assign sel_sum  = (cmd_i.ch == CH_RIGHT) ? sum_r_q : sum_l_q;
  assign sel_sq   = (cmd_i.ch == CH_RIGHT) ? sq_r_q : sq_l_q;
  assign mag      = sel_sum[SUM_W-1] ? (~sel_sum + 1'b1) : sel_sum;
  assign den_full = mag * mag;
  assign plo_full = cnt_q * sel_sq[SQ_SPLIT-1:0];
  assign phi_full = cnt_q * sel_sq[SQ_W-1:SQ_SPLIT];
  assign nn_full  = cnt_q * cnt_q;

  logic [PROD_W-1:0]              den_q, nsq_q, diff_q;
  logic [CNT_W+SQ_SPLIT-1:0]      plo_q;
  logic [CNT_W+SQ_W-SQ_SPLIT-1:0] phi_q;
  logic [NN_W-1:0]                nn_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pre0) begin
      den_q <= den_full;
      plo_q <= plo_full;
      nn_q  <= nn_full;
    end
    if (cmd_i.pre1) begin
      phi_q <= phi_full;
    end
    if (cmd_i.pre2) begin
      nsq_q <= PROD_W'({phi_q, {SQ_SPLIT{1'b0}}}) + PROD_W'(plo_q);
    end
    if (cmd_i.pre3) begin
      diff_q <= (nsq_q >= den_q) ? (nsq_q - den_q) : '0;
    end
  end

  logic [PROD_W-1:0] quo;
  logic [ROOT_W-1:0] root;
  logic              div_done, sqrt_done;

  sbrpm_div #(
    .NUM_W (PROD_W),
    .DEN_W (NN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (diff_q),
    .den_i   (nn_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  sbrpm_sqrt #(
    .IN_W (PROD_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (quo),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign status_o = '{div_done: div_done, sqrt_done: sqrt_done};

  logic [SAMP_W-1:0] rms_l_q, rms_r_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_rms) begin
      if (cmd_i.ch == CH_RIGHT) begin
        rms_r_q <= root[SAMP_W-1:0];
      end else begin
        rms_l_q <= root[SAMP_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      left_rms_o    <= rms_l_q;
      left_peak_o   <= peak_l_q;
      right_rms_o   <= rms_r_q;
      right_peak_o  <= peak_r_q;
      frame_total_o <= cnt_q;
      overrun_o     <= drop_q;
    end
  end

endmodule

FILE: hdl/sbrpm_ctrl.sv
`timescale 1ns / 1ps
// Controller: frame intake, per-channel RMS sequence and result handshake.
module sbrpm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  sbrpm_pkg::status_t status_i,
  output sbrpm_pkg::cmd_t    cmd_o
);

  import sbrpm_pkg::*;

  localparam logic [3:0] S_RUN   = 4'd0;
  localparam logic [3:0] S_DRAIN = 4'd1;
  localparam logic [3:0] S_PRE0  = 4'd2;
  localparam logic [3:0] S_PRE1  = 4'd3;
  localparam logic [3:0] S_PRE2  = 4'd4;
  localparam logic [3:0] S_PRE3  = 4'd5;
  localparam logic [3:0] S_DIVGO = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_SQGO  = 4'd8;
  localparam logic [3:0] S_SQW   = 4'd9;
  localparam logic [3:0] S_HOLD  = 4'd10;

  logic [3:0] state_q, state_d;
  logic       ch_q, ch_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, load;

  assign in_ready_o = (state_q == S_RUN);
  assign accept     = in_valid_i && in_ready_o;
  assign load       = (state_q == S_HOLD) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    unique case (state_q)
      S_RUN: begin
        if (accept && in_last_i) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_PRE0;
        ch_d    = CH_LEFT;
      end
      S_PRE0:  state_d = S_PRE1;
      S_PRE1:  state_d = S_PRE2;
      S_PRE2:  state_d = S_PRE3;
      S_PRE3:  state_d = S_DIVGO;
      S_DIVGO: state_d = S_DIVW;
      S_DIVW: begin
        if (status_i.div_done) begin
          state_d = S_SQGO;
        end
      end
      S_SQGO:  state_d = S_SQW;
      S_SQW: begin
        if (status_i.sqrt_done) begin
          if (ch_q == CH_LEFT) begin
            ch_d    = CH_RIGHT;
            state_d = S_PRE0;
          end else begin
            state_d = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (load) begin
          state_d = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_comb begin
    priority if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      ch_q        <= CH_LEFT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.ch         = ch_q;
    cmd_o.pre0       = (state_q == S_PRE0);
    cmd_o.pre1       = (state_q == S_PRE1);
    cmd_o.pre2       = (state_q == S_PRE2);
    cmd_o.pre3       = (state_q == S_PRE3);
    cmd_o.div_start  = (state_q == S_DIVGO);
    cmd_o.sqrt_start = (state_q == S_SQGO);
    cmd_o.take_rms   = (state_q == S_SQW) && status_i.sqrt_done;
    cmd_o.load_out   = load;
    cmd_o.clear      = load;
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/stereo_block_rms_peak_meter_core.sv
`timescale 1ns / 1ps
// Top level of the stereo block RMS and peak level meter.
//
// Input stream: one stereo frame per transfer. tdata carries the raw left and
// right 32-bit words; the sample of each is its upper 24 bits. tlast marks
// the final frame of a measurement block.
// Output stream: one result per block, sent after the frame marked last:
// per channel the mean-removed RMS and the peak magnitude, the frame count,
// and in tuser an overrun flag set when frames past MAX_FRAMES were dropped.
// Throughput: frames inside a block are taken one per cycle. After the last
// frame, intake stops while the block is reduced: the accumulators drain,
// then per channel the multiply and subtract steps run, followed by the
// bit-serial divide by n*n (start, 64 quotient bits, done) and the
// bit-serial square root (start, 32 root bits, done), and finally the result
// is loaded. Intake resumes in the same cycle that m_axis_tvalid rises.
// The result sits in an output register, so the next block starts filling
// as soon as it is loaded; a stalled receiver only blocks intake once the
// following block has also finished and needs that register.
// Reset clears all accumulators, the frame count and the output valid.
module stereo_block_rms_peak_meter_core #(
  parameter int unsigned MAX_FRAMES = sbrpm_pkg::MAX_FRAMES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] left_word, [63:32] right_word
  input  logic [sbrpm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [23:0] left_rms, [47:24] left_peak, [71:48] right_rms, [95:72] right_peak,
  // [104:96] frame_total, rest zero
  output logic [sbrpm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] overrun
  output logic                                m_axis_tuser
);

  import sbrpm_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic [SAMP_W-1:0] left_rms, left_peak, right_rms, right_peak;
  logic [CNT_W-1:0]  frame_total;
  logic              overrun;

  // Sequence intake, the RMS reduction and the result transfer.
  sbrpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Accumulate frames and compute the per-channel figures.
  sbrpm_datapath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .left_word_i   (s_axis_tdata[WORD_W-1:0]),
    .right_word_i  (s_axis_tdata[2*WORD_W-1:WORD_W]),
    .left_rms_o    (left_rms),
    .left_peak_o   (left_peak),
    .right_rms_o   (right_rms),
    .right_peak_o  (right_peak),
    .frame_total_o (frame_total),
    .overrun_o     (overrun)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, frame_total, right_peak, right_rms,
                         left_peak, left_rms};
  assign m_axis_tuser = overrun;

  localparam logic [SAMP_W-1:0] FULL_SCALE = SAMP_W'(1) << (SAMP_W - 1);

  // Intake must stop right after the last frame of a block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("frame taken after the last frame of a block");

  // A result always covers between one and MAX_FRAMES frames.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (frame_total != '0) && (frame_total <= CNT_W'(MAX_FRAMES)))
    else $error("frame total out of range");

  // Frames are only dropped once the block is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && overrun) |-> (frame_total == CNT_W'(MAX_FRAMES)))
    else $error("overrun with a block that is not full");

  // Levels never exceed the magnitude of the most negative sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (left_peak <= FULL_SCALE) && (right_peak <= FULL_SCALE) &&
                      (left_rms <= FULL_SCALE) && (right_rms <= FULL_SCALE))
    else $error("level above full scale");

endmodule
